/* hdl/wcep_pkg.sv */
// ----------------------------------------------------------------------------
// wcep_pkg
// Shared types and constants of the weighted count equal partition unit.
// ----------------------------------------------------------------------------
package wcep_pkg;

    localparam int COUNT_W            = 14;
    localparam int NUM_VALUES         = 6;
    localparam int VIDX_W             = 3;
    localparam int TOTAL_W            = 19;
    localparam int CHUNK_W            = 17;
    localparam int WORD_W             = 64;
    localparam int WORD_SHIFT         = 6;
    localparam int SHIFT_W            = 7;
    localparam int HALF_LIMIT_DEFAULT = 16383;

    localparam logic [VIDX_W-1:0] LAST_VALUE = VIDX_W'(NUM_VALUES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_CHECK,
        ST_CLEAR,
        ST_VALUE,
        ST_CHUNK,
        ST_TEST,
        ST_PREFETCH,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINAL_RD,
        ST_FINAL_DATA,
        ST_OUT
    } wcep_state_t;

    typedef struct packed {
        logic load_item;
        logic acc_step;
        logic check;
        logic clear_step;
        logic load_value;
        logic next_value;
        logic chunk_step;
        logic sweep_init;
        logic prefetch;
        logic sweep_step;
        logic final_read;
        logic final_capture;
        logic publish;
    } wcep_cmd_t;

    typedef struct packed {
        logic last_value;
        logic early_done;
        logic j_at_zero;
        logic left_zero;
        logic chunk_skip;
        logic j_at_q;
        logic out_free;
    } wcep_status_t;

endpackage

/* hdl/wcep_ram.sv */
// ----------------------------------------------------------------------------
// wcep_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wcep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hdl/wcep_ctrl.sv */
// ----------------------------------------------------------------------------
// wcep_ctrl
// Sequencer: total, checks, bitmap clear, chunk passes, final lookup, output.
// ----------------------------------------------------------------------------
module wcep_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wcep_pkg::wcep_status_t st,
    output wcep_pkg::wcep_cmd_t    cmd
);

    import wcep_pkg::*;

    wcep_state_t state_reg;
    wcep_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                if (st.last_value)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = st.early_done ? ST_OUT : ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (st.j_at_zero)
                begin
                    state_next = ST_VALUE;
                end
            end
            ST_VALUE:
            begin
                state_next = ST_CHUNK;
            end
            ST_CHUNK:
            begin
                if (!st.left_zero)
                begin
                    state_next = ST_TEST;
                end
                else if (st.last_value)
                begin
                    state_next = ST_FINAL_RD;
                end
                else
                begin
                    state_next = ST_VALUE;
                end
            end
            ST_TEST:
            begin
                state_next = st.chunk_skip ? ST_CHUNK : ST_PREFETCH;
            end
            ST_PREFETCH:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (st.j_at_q)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHUNK;
            end
            ST_FINAL_RD:
            begin
                state_next = ST_FINAL_DATA;
            end
            ST_FINAL_DATA:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_TOTAL:
            begin
                cmd.acc_step = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_VALUE:
            begin
                cmd.load_value = 1'b1;
            end
            ST_CHUNK:
            begin
                cmd.chunk_step = !st.left_zero;
                cmd.next_value = st.left_zero && !st.last_value;
            end
            ST_TEST:
            begin
                cmd.sweep_init = !st.chunk_skip;
            end
            ST_PREFETCH:
            begin
                cmd.prefetch = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_FINAL_RD:
            begin
                cmd.final_read = 1'b1;
            end
            ST_FINAL_DATA:
            begin
                cmd.final_capture = 1'b1;
            end
            ST_OUT:
            begin
                cmd.publish = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/wcep_dp.sv */
// ----------------------------------------------------------------------------
// wcep_dp
// Datapath: counts, weighted total, chunk split, bitmap word update, output.
// ----------------------------------------------------------------------------
module wcep_dp #(
    parameter int HALF_LIMIT = wcep_pkg::HALF_LIMIT_DEFAULT,
    parameter int MAP_WORDS  = (HALF_LIMIT / 64) + 1,
    parameter int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic [wcep_pkg::NUM_VALUES-1:0][wcep_pkg::COUNT_W-1:0] counts,
    input  wcep_pkg::wcep_cmd_t                                  cmd,
    output wcep_pkg::wcep_status_t                               st,
    output logic                                                 ram_we,
    output logic [ADDR_W-1:0]                                    ram_waddr,
    output logic [wcep_pkg::WORD_W-1:0]                          ram_wdata,
    output logic [ADDR_W-1:0]                                    ram_raddr_a,
    input  logic [wcep_pkg::WORD_W-1:0]                          ram_rdata_a,
    output logic [ADDR_W-1:0]                                    ram_raddr_b,
    input  logic [wcep_pkg::WORD_W-1:0]                          ram_rdata_b,
    input  logic                                                 out_ready,
    output logic                                                 out_valid,
    output logic                                                 divisible,
    output logic                                                 too_large,
    output logic                                                 all_zero
);

    import wcep_pkg::*;

    localparam int HALF_W = $clog2(HALF_LIMIT + 1);

    logic [COUNT_W-1:0] cnt_reg [NUM_VALUES];
    logic [VIDX_W-1:0]  vidx_reg;
    logic [TOTAL_W-1:0] acc_reg;
    logic [HALF_W-1:0]  half_reg;
    logic [COUNT_W-1:0] left_reg;
    logic [COUNT_W-1:0] k_reg;
    logic [CHUNK_W-1:0] w_reg;
    logic [ADDR_W-1:0]  q_reg;
    logic [WORD_SHIFT-1:0] r_reg;
    logic [ADDR_W-1:0]  j_reg;
    logic [WORD_W-1:0]  hi_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic               lo_ok_reg;
    logic               pf_pipe_reg;
    logic               sw_pipe_reg;
    logic               hit_reg;
    logic               flag_zero_reg;
    logic               flag_large_reg;
    logic               out_valid_reg;
    logic               divisible_reg;
    logic               too_large_reg;
    logic               all_zero_reg;

    logic [COUNT_W-1:0] cnt_sel;
    logic [VIDX_W-1:0]  val;
    logic [TOTAL_W-1:0] acc_next;
    logic               any_count;
    logic               total_odd;
    logic               half_large;
    logic [ADDR_W-1:0]  top;
    logic [COUNT_W-1:0] take;
    logic [CHUNK_W-1:0] w_next;
    logic [WORD_W-1:0]  lo_word;
    logic [WORD_W-1:0]  shifted;
    logic [WORD_W-1:0]  new_word;

    assign cnt_sel    = cnt_reg[vidx_reg];
    assign val        = vidx_reg + VIDX_W'(1);
    assign acc_next   = acc_reg + TOTAL_W'(cnt_sel) * TOTAL_W'(val);
    assign any_count  = (acc_reg != '0);
    assign total_odd  = acc_reg[0];
    assign half_large = (acc_reg >> 1) > TOTAL_W'(HALF_LIMIT);
    assign top        = ADDR_W'(half_reg >> WORD_SHIFT);
    assign take       = (k_reg < left_reg) ? k_reg : left_reg;
    assign w_next     = CHUNK_W'(take) * CHUNK_W'(val);

    assign lo_word  = lo_ok_reg ? ram_rdata_b : '0;
    assign shifted  = (hi_reg << r_reg)
                    | (lo_word >> (SHIFT_W'(WORD_W) - SHIFT_W'(r_reg)));
    assign new_word = ram_rdata_a | shifted;

    assign st.last_value = (vidx_reg == LAST_VALUE);
    assign st.early_done = !any_count || total_odd || half_large;
    assign st.j_at_zero  = (j_reg == '0);
    assign st.left_zero  = (left_reg == '0);
    assign st.chunk_skip = (w_reg > CHUNK_W'(half_reg));
    assign st.j_at_q     = (j_reg == q_reg);
    assign st.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_we    = cmd.clear_step || sw_pipe_reg;
        ram_waddr = cmd.clear_step ? j_reg : wr_addr_reg;
        if (cmd.clear_step)
        begin
            ram_wdata = (j_reg == '0) ? WORD_W'(1) : '0;
        end
        else
        begin
            ram_wdata = new_word;
        end
        ram_raddr_a = cmd.final_read ? top : j_reg;
        ram_raddr_b = cmd.prefetch ? (top - q_reg) : (j_reg - q_reg - ADDR_W'(1));
    end

    // item registers and chunk bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                cnt_reg[i] <= counts[i];
            end
            acc_reg  <= '0;
            vidx_reg <= '0;
        end
        if (cmd.acc_step)
        begin
            acc_reg <= acc_next;
            if (!st.last_value)
            begin
                vidx_reg <= vidx_reg + VIDX_W'(1);
            end
        end
        if (cmd.check)
        begin
            half_reg       <= HALF_W'(acc_reg >> 1);
            j_reg          <= ADDR_W'(acc_reg >> (WORD_SHIFT + 1));
            vidx_reg       <= '0;
            hit_reg        <= 1'b0;
            flag_zero_reg  <= !any_count;
            flag_large_reg <= any_count && !total_odd && half_large;
        end
        if (cmd.clear_step)
        begin
            j_reg <= j_reg - ADDR_W'(1);
        end
        if (cmd.load_value)
        begin
            left_reg <= cnt_sel;
            k_reg    <= COUNT_W'(1);
        end
        if (cmd.next_value)
        begin
            vidx_reg <= vidx_reg + VIDX_W'(1);
        end
        if (cmd.chunk_step)
        begin
            w_reg    <= w_next;
            left_reg <= left_reg - take;
            k_reg    <= k_reg << 1;
        end
        if (cmd.sweep_init)
        begin
            j_reg <= top;
            q_reg <= ADDR_W'(w_reg >> WORD_SHIFT);
            r_reg <= w_reg[WORD_SHIFT-1:0];
        end
        if (cmd.sweep_step)
        begin
            j_reg       <= j_reg - ADDR_W'(1);
            wr_addr_reg <= j_reg;
            lo_ok_reg   <= (j_reg != q_reg);
        end
        if (pf_pipe_reg)
        begin
            hi_reg <= ram_rdata_b;
        end
        else if (sw_pipe_reg)
        begin
            hi_reg <= lo_word;
        end
        if (cmd.final_capture)
        begin
            hit_reg <= ram_rdata_a[half_reg[WORD_SHIFT-1:0]];
        end
        if (cmd.publish)
        begin
            divisible_reg <= hit_reg;
            too_large_reg <= flag_large_reg;
            all_zero_reg  <= flag_zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_pipe_reg   <= 1'b0;
            sw_pipe_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pf_pipe_reg <= cmd.prefetch;
            sw_pipe_reg <= cmd.sweep_step;
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign divisible = divisible_reg;
    assign too_large = too_large_reg;
    assign all_zero  = all_zero_reg;

endmodule

/* hdl/weighted_count_equal_partition_unit.sv */
// ----------------------------------------------------------------------------
// weighted_count_equal_partition_unit
// Decides whether counted items worth 1..6 split into two equal-weight halves.
// ----------------------------------------------------------------------------
// One item is worked at a time; a finished beat waits in the output register
// while the next item is taken. An item that is all-zero, odd or too large
// takes only the weighted total over the six values, the checks, the publish
// and the idle state that takes the next beat. Otherwise the unit also clears
// the bitmap words from half/64 down to zero, loads each value, steps through
// the binary chunks of each count, makes a pass for each chunk that is not
// skipped and ends with the final lookup. Publishing stalls while the output
// register still holds a beat that has not been taken. The chunk passes
// dominate: each walks the bitmap RAM one 64-bit word per cycle through its
// two read ports and one write port, up to 84 passes over 256 words at worst.
module weighted_count_equal_partition_unit #(
    parameter int HALF_LIMIT = wcep_pkg::HALF_LIMIT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_one,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_two,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_three,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_four,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_five,
    input  logic [wcep_pkg::COUNT_W-1:0] count_value_six,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         divisible,
    output logic                         too_large,
    output logic                         all_zero
);

    import wcep_pkg::*;

    localparam int MAP_WORDS = (HALF_LIMIT / 64) + 1;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [NUM_VALUES-1:0][COUNT_W-1:0] counts;
    wcep_cmd_t          cmd;
    wcep_status_t       st;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr_a;
    logic [WORD_W-1:0]  ram_rdata_a;
    logic [ADDR_W-1:0]  ram_raddr_b;
    logic [WORD_W-1:0]  ram_rdata_b;

    assign counts = {count_value_six, count_value_five, count_value_four,
                     count_value_three, count_value_two, count_value_one};

    wcep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    wcep_dp #(
        .HALF_LIMIT (HALF_LIMIT),
        .MAP_WORDS  (MAP_WORDS),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .counts      (counts),
        .cmd         (cmd),
        .st          (st),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_rdata_a (ram_rdata_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_b (ram_rdata_b),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .divisible   (divisible),
        .too_large   (too_large),
        .all_zero    (all_zero)
    );

    wcep_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (ADDR_W)
    ) u_map_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken while an item is still in work");

    a_flags_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(divisible && too_large) && !(divisible && all_zero)
                       && !(too_large && all_zero))
    ) else $error("more than one result flag set");

    a_result_after_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready)
    ) else $error("result beat appeared without an item in work");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Equal-weight partition checks for weighted_count_equal_partition_unit.
// ----------------------------------------------------------------------------
// Sends beats of six counts (items worth 1..6) and checks each answer against
// a bounded subset-sum computed here on a wide bit vector. A directed set
// covers the all-zero marker, odd totals, the half-total limit on both sides
// and chunks that outweigh half the total. Random beats follow. Most are
// small counts, with some long single-value runs, some near the limit and
// some full-range noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import wcep_pkg::*;

    localparam int HALF_LIMIT   = HALF_LIMIT_DEFAULT;
    localparam int RANDOM_ITEMS = 125;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 50;

    typedef logic [NUM_VALUES-1:0][COUNT_W-1:0] count_set_t;

    typedef struct packed {
        logic divisible;
        logic too_large;
        logic all_zero;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COUNT_W-1:0] count_value_one = '0;
    logic [COUNT_W-1:0] count_value_two = '0;
    logic [COUNT_W-1:0] count_value_three = '0;
    logic [COUNT_W-1:0] count_value_four = '0;
    logic [COUNT_W-1:0] count_value_five = '0;
    logic [COUNT_W-1:0] count_value_six = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               divisible;
    logic               too_large;
    logic               all_zero;

    count_set_t         pending_counts[$];
    verdict_t           expected_verdicts[$];
    logic [HALF_LIMIT:0] sums_bitmap;

    logic     in_taken;
    int       send_gap;
    int       ready_stall;
    int       stall_roll;
    int       error_count;
    int       cycle_count;
    int       beats_sent;
    int       beats_checked;
    int       split_count;
    int       no_split_count;
    int       over_limit_count;
    int       marker_count;
    count_set_t next_counts;
    verdict_t   oldest_verdict;

    weighted_count_equal_partition_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .count_value_one   (count_value_one),
        .count_value_two   (count_value_two),
        .count_value_three (count_value_three),
        .count_value_four  (count_value_four),
        .count_value_five  (count_value_five),
        .count_value_six   (count_value_six),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .divisible         (divisible),
        .too_large         (too_large),
        .all_zero          (all_zero)
    );

    always #10 clk = ~clk;

    function automatic verdict_t solve_partition(input count_set_t counts);
        verdict_t answer;
        int       total;
        int       half;
        int       left;
        int       step;
        int       take;
        int       weight;
        logic     any_count;
        answer    = '0;
        total     = 0;
        any_count = 1'b0;
        for (int v = 0; v < NUM_VALUES; v++)
        begin
            total += int'(counts[v]) * (v + 1);
            if (counts[v] != '0)
                any_count = 1'b1;
        end
        if (!any_count)
        begin
            answer.all_zero = 1'b1;
            return answer;
        end
        if (total % 2 != 0)
            return answer;
        half = total / 2;
        if (half > HALF_LIMIT)
        begin
            answer.too_large = 1'b1;
            return answer;
        end
        sums_bitmap    = '0;
        sums_bitmap[0] = 1'b1;
        for (int v = 0; v < NUM_VALUES; v++)
        begin
            left = int'(counts[v]);
            step = 1;
            while (left != 0)
            begin
                take   = (step < left) ? step : left;
                weight = take * (v + 1);
                if (weight <= half)
                    sums_bitmap = sums_bitmap | (sums_bitmap << weight);
                left -= take;
                step = step << 1;
            end
        end
        answer.divisible = sums_bitmap[half];
        return answer;
    endfunction

    function automatic count_set_t random_counts();
        count_set_t counts;
        int         kind;
        int         v;
        counts = '0;
        kind   = $urandom_range(0, 99);
        if (kind < 55)
        begin
            for (v = 0; v < NUM_VALUES; v++)
                if ($urandom_range(0, 2) != 0)
                    counts[v] = COUNT_W'($urandom_range(0, 12));
        end
        else if (kind < 70)
        begin
            v = $urandom_range(0, 1);
            counts[v] = COUNT_W'($urandom_range(0, 16383));
            v = $urandom_range(2, 5);
            counts[v] = COUNT_W'($urandom_range(0, 4));
        end
        else if (kind < 80)
        begin
            counts[5] = COUNT_W'($urandom_range(5440, 5461));
            counts[0] = COUNT_W'($urandom_range(0, 30));
            counts[2] = COUNT_W'($urandom_range(0, 6));
        end
        else if (kind < 96)
        begin
            for (v = 0; v < NUM_VALUES; v++)
                counts[v] = COUNT_W'($urandom_range(0, 16383));
        end
        return counts;
    endfunction

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic count_set_t make_counts(input int c1, input int c2, input int c3,
                                               input int c4, input int c5, input int c6);
        count_set_t counts;
        counts[0] = c1[COUNT_W-1:0];
        counts[1] = c2[COUNT_W-1:0];
        counts[2] = c3[COUNT_W-1:0];
        counts[3] = c4[COUNT_W-1:0];
        counts[4] = c5[COUNT_W-1:0];
        counts[5] = c6[COUNT_W-1:0];
        return counts;
    endfunction

    task automatic queue_item(input count_set_t counts);
        pending_counts = {pending_counts, counts};
    endtask

    task automatic compare_flag(input string flag_name, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, flag_name, want, got);
            error_count++;
        end
    endtask

    // Accept flag, seen by the driver on the following falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && in_ready;
    end

    // Input driver: hold a beat until taken, then idle or advance
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_counts.size() > 0)
            begin
                next_counts = pending_counts.pop_front();
                count_value_one   <= next_counts[0];
                count_value_two   <= next_counts[1];
                count_value_three <= next_counts[2];
                count_value_four  <= next_counts[3];
                count_value_five  <= next_counts[4];
                count_value_six   <= next_counts[5];
                in_valid <= 1'b1;
                send_gap = random_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (ready_stall > 0)
        begin
            ready_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 8)
                ready_stall = $urandom_range(1, 4);
            else if (stall_roll < 10)
                ready_stall = $urandom_range(20, 80);
        end
    end

    // Monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                oldest_verdict = solve_partition({count_value_six, count_value_five,
                                                  count_value_four, count_value_three,
                                                  count_value_two, count_value_one});
                expected_verdicts = {expected_verdicts, oldest_verdict};
                beats_sent++;
                if (oldest_verdict.all_zero)
                    marker_count++;
                else if (oldest_verdict.too_large)
                    over_limit_count++;
                else if (oldest_verdict.divisible)
                    split_count++;
                else
                    no_split_count++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual div=%0b big=%0b zero=%0b",
                             $time, divisible, too_large, all_zero);
                    error_count++;
                end
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    compare_flag("divisible", oldest_verdict.divisible, divisible);
                    compare_flag("too_large", oldest_verdict.too_large, too_large);
                    compare_flag("all_zero", oldest_verdict.all_zero, all_zero);
                    beats_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d beats outstanding", $time,
                     expected_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        error_count      = 0;
        cycle_count      = 0;
        beats_sent       = 0;
        beats_checked    = 0;
        split_count      = 0;
        no_split_count   = 0;
        over_limit_count = 0;
        marker_count     = 0;
        send_gap         = 0;
        ready_stall      = 0;

        queue_item(make_counts(0, 0, 0, 0, 0, 0));
        queue_item(make_counts(16383, 16383, 16383, 16383, 16383, 16383));
        queue_item(make_counts(1, 0, 0, 0, 0, 0));
        queue_item(make_counts(2, 0, 0, 0, 0, 0));
        queue_item(make_counts(0, 1, 0, 0, 0, 0));
        queue_item(make_counts(0, 0, 0, 0, 0, 3));
        queue_item(make_counts(0, 0, 0, 0, 0, 5461));
        queue_item(make_counts(6, 0, 0, 0, 0, 5460));
        queue_item(make_counts(2, 16383, 0, 0, 0, 0));
        queue_item(make_counts(8192, 0, 0, 0, 0, 0));
        queue_item(make_counts(0, 0, 1, 0, 1, 0));
        queue_item(make_counts(1, 1, 1, 1, 1, 1));
        queue_item(make_counts(2, 0, 0, 0, 0, 2));
        queue_item(make_counts(0, 0, 0, 0, 2, 0));
        queue_item(make_counts(0, 0, 0, 1, 0, 1));
        queue_item(make_counts(0, 0, 2, 0, 0, 1));
        queue_item(make_counts('h2AAA, 'h1555, 'h2AAA, 'h1555, 'h2AAA, 'h1555));
        queue_item(make_counts('h1555, 'h2AAA, 'h1555, 'h2AAA, 'h1555, 'h2AAA));
        queue_item(make_counts(0, 0, 16383, 0, 0, 0));
        queue_item(make_counts(3, 2, 1, 0, 0, 0));
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_item(random_counts());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_counts.size() > 0 || in_valid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats, checked %0d answers in %0d cycles", beats_sent,
                 beats_checked, cycle_count);
        $display("Split %0d, no split %0d, over limit %0d, zero markers %0d", split_count,
                 no_split_count, over_limit_count, marker_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
